@@ src/record_stack_with_sort_defines.svh @@
// Assertion macros for the record stack with sort.
`ifndef RECORD_STACK_WITH_SORT_DEFINES_SVH
`define RECORD_STACK_WITH_SORT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define RSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("record stack check failed");
// Check a property on every rising clock edge, reset included.
`define RSS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("record stack check failed");
`else
`define RSS_ASSERT(label, clk, rst, prop)
`define RSS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ src/rss_pkg.sv @@
// Shared constants, codes and payload types of the record stack with sort.
`timescale 1ns / 1ps
`default_nettype none
package rss_pkg;
   localparam int DEPTH   = 8;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);
   localparam logic [COUNT_W-1:0] ONE_COUNT  = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] ZERO_COUNT = COUNT_W'(0);

   // operation codes
   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;
   localparam logic [1:0] FUNC_SORT = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [63:0]        record_key;
      logic signed [15:0] score;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [63:0]        out_key;
      logic signed [15:0] out_score;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [63:0]        key;
      logic signed [15:0] score;
   } rec_type;
endpackage
`default_nettype wire

@@ src/rss_store.sv @@
// Record storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rss_store (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [rss_pkg::ADDR_W-1:0] wr_addr,
   input  wire rss_pkg::rec_type           wr_data,
   input  wire logic [rss_pkg::ADDR_W-1:0] rd_addr,
   output rss_pkg::rec_type                rd_data
);
   rss_pkg::rec_type mem_ff [rss_pkg::DEPTH];
   rss_pkg::rec_type rd_data_ff;

   // write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ src/rss_cmp_swap.sv @@
// Shared compare-and-swap unit of the bubble sort.
`timescale 1ns / 1ps
`default_nettype none
module rss_cmp_swap (
   input  wire rss_pkg::rec_type hold,
   input  wire rss_pkg::rec_type next,
   output rss_pkg::rec_type      wr_rec,
   output rss_pkg::rec_type      hold_next
);
   logic swap;

   // carry the lower score upward; equal scores keep their order
   always_comb begin
      swap = (hold.score < next.score);
      if (swap) begin
         wr_rec    = next;
         hold_next = hold;
      end else begin
         wr_rec    = hold;
         hold_next = next;
      end
   end
endmodule
`default_nettype wire

@@ src/record_stack_with_sort.sv @@
// Top level: sequencer, fill count and result register of the record stack.
//
// Request channel req_*: one item per operation (push, pop, read out, sort).
// Response channel rsp_*: registered results; last_of_run marks the final
// result of each request. Both sides use valid/stall; an item moves on a
// rising edge with valid high and stall low.
// Push, pop, sort of one entry and every request on an empty stack finish
// in the accept cycle; their single result appears on the next cycle.
// Read out emits the records one at a time from top to bottom, each read
// going through the registered port of the record store.
// Sort runs passes of a single compare-and-swap unit over the store; each
// pass loads entry 0, steps the unit up to the last unsorted entry and
// writes the carried record there, then the next pass stops one lower.
// The block takes a new request only when idle and the result register is
// free or being drained; a stalled result holds and stalls requests.
// Reset empties the stack and clears the result valid flag; no clearing pass
// is needed since only written entries are read.
`timescale 1ns / 1ps
`default_nettype none
`include "record_stack_with_sort_defines.svh"
module record_stack_with_sort (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rss_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rss_pkg::rsp_type      rsp_data
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_HOLD,
      ST_SORT_STEP,
      ST_SORT_TAIL,
      ST_SORT_DONE,
      ST_RD_ADDR,
      ST_RD_OUT
   } state_type;

   state_type                      state_ff, state_in;
   logic [rss_pkg::COUNT_W-1:0]    fill_ff, fill_in;
   logic [rss_pkg::ADDR_W-1:0]     pos_ff, pos_in;
   logic [rss_pkg::ADDR_W-1:0]     last_ff, last_in;
   logic [rss_pkg::ADDR_W-1:0]     idx_ff, idx_in;
   rss_pkg::rec_type               hold_ff, hold_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rss_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                           out_free;
   logic                           accept;
   logic [rss_pkg::COUNT_W-1:0]    fill_dec;
   logic [rss_pkg::ADDR_W:0]       pos_plus2;
   logic [rss_pkg::ADDR_W-1:0]     pos_plus1;

   logic                           wr_en;
   logic [rss_pkg::ADDR_W-1:0]     wr_addr;
   rss_pkg::rec_type               wr_data;
   logic [rss_pkg::ADDR_W-1:0]     rd_addr;
   rss_pkg::rec_type               rd_data;
   rss_pkg::rec_type               cmp_wr;
   rss_pkg::rec_type               cmp_hold;
   rss_pkg::rec_type               push_rec;

   rss_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rss_cmp_swap u_cmp (
      .hold      (hold_ff),
      .next      (rd_data),
      .wr_rec    (cmp_wr),
      .hold_next (cmp_hold)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign fill_dec  = fill_ff - rss_pkg::ONE_COUNT;
   assign pos_plus1 = pos_ff + rss_pkg::ADDR_W'(1);
   assign pos_plus2 = {1'b0, pos_ff} + (rss_pkg::ADDR_W + 1)'(2);
   assign push_rec  = '{key: req_data.record_key, score: req_data.score};

   // pick the read address for the coming cycle
   always_comb begin
      unique case (state_ff)
         ST_SORT_HOLD: rd_addr = rss_pkg::ADDR_W'(1);
         ST_SORT_STEP: rd_addr = pos_plus2[rss_pkg::ADDR_W-1:0];
         ST_RD_ADDR,
         ST_RD_OUT:    rd_addr = idx_ff;
         default:      rd_addr = '0;
      endcase
   end

   // pick the write port: push, sort step or end of pass
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = push_rec;
      unique case (state_ff)
         ST_IDLE: begin
            wr_en   = accept && (req_data.func == rss_pkg::FUNC_PUSH)
                      && (fill_ff != rss_pkg::FULL_COUNT);
            wr_addr = fill_ff[rss_pkg::ADDR_W-1:0];
            wr_data = push_rec;
         end
         ST_SORT_STEP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = cmp_wr;
         end
         ST_SORT_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = last_ff;
            wr_data = hold_ff;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   // sequence the operations and load the result register
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: rss_pkg::STATUS_OK, out_key: '0,
                                out_score: '0, last_of_run: 1'b1};
               priority if (req_data.func == rss_pkg::FUNC_PUSH) begin
                  if (fill_ff == rss_pkg::FULL_COUNT) begin
                     rsp_data_in.status = rss_pkg::STATUS_FULL;
                  end else begin
                     fill_in = fill_ff + rss_pkg::ONE_COUNT;
                  end
               end else if (fill_ff == rss_pkg::ZERO_COUNT) begin
                  rsp_data_in.status = rss_pkg::STATUS_EMPTY;
               end else if (req_data.func == rss_pkg::FUNC_POP) begin
                  fill_in = fill_dec;
               end else if (req_data.func == rss_pkg::FUNC_READ) begin
                  rsp_valid_in = 1'b0;
                  idx_in       = fill_dec[rss_pkg::ADDR_W-1:0];
                  state_in     = ST_RD_ADDR;
               end else if (fill_ff != rss_pkg::ONE_COUNT) begin
                  // sort of two or more entries; entry 0 read is under way
                  rsp_valid_in = 1'b0;
                  last_in      = fill_dec[rss_pkg::ADDR_W-1:0];
                  state_in     = ST_SORT_HOLD;
               end
            end
         end
         ST_SORT_HOLD: begin
            hold_in  = rd_data;
            pos_in   = '0;
            state_in = ST_SORT_STEP;
         end
         ST_SORT_STEP: begin
            hold_in = cmp_hold;
            if (pos_plus1 == last_ff) begin
               state_in = ST_SORT_TAIL;
            end else begin
               pos_in = pos_plus1;
            end
         end
         ST_SORT_TAIL: begin
            last_in = last_ff - rss_pkg::ADDR_W'(1);
            if (last_ff == rss_pkg::ADDR_W'(1)) begin
               state_in = ST_SORT_DONE;
            end else begin
               state_in = ST_SORT_HOLD;
            end
         end
         ST_SORT_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: rss_pkg::STATUS_OK, out_key: '0,
                                out_score: '0, last_of_run: 1'b1};
               state_in     = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: rss_pkg::STATUS_OK, out_key: rd_data.key,
                                out_score: rd_data.score,
                                last_of_run: (idx_ff == '0)};
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - rss_pkg::ADDR_W'(1);
                  state_in = ST_RD_ADDR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state, counters and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RSS_ASSERT(a_fill_bound, clock, reset, fill_ff <= rss_pkg::FULL_COUNT)
   `RSS_ASSERT(a_busy_stalls, clock, reset, (state_ff != ST_IDLE) |-> req_stall)
   `RSS_ASSERT(a_fill_busy_stable, clock, reset, (state_ff != ST_IDLE) |=> $stable(fill_ff))
   `RSS_ASSERT_ALWAYS(a_error_is_last, clock, (rsp_valid_ff && (rsp_data_ff.status != rss_pkg::STATUS_OK)) |-> rsp_data_ff.last_of_run)
endmodule
`default_nettype wire

@@ dv/record_stack_with_sort_test.sv @@
// Testbench for the record stack with sort: scripted and random operations checked by a predictor.
`timescale 1ns / 1ps
module record_stack_with_sort_test;
   localparam int RANDOM_ITEMS = 190;
   localparam int CALM_ITEMS   = 40;
   localparam int SEGMENT_LEN  = 30;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 60;
   localparam int SCRIPT_LEN   = 21;

   typedef struct {
      rss_pkg::req_type req;
      bit               typed;
      rss_pkg::rsp_type want;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid;
   logic             req_stall;
   rss_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rss_pkg::rsp_type rsp_data;

   // shadow copy of the stack
   rss_pkg::rec_type shadow_stack [rss_pkg::DEPTH];
   int unsigned      shadow_fill;

   rss_pkg::rsp_type pending_results [$];
   int unsigned      mismatch_count;
   int unsigned      cycle_count;
   int unsigned      result_index;
   int unsigned      gap_odds;
   int unsigned      stall_odds;

   // opening script: empty-stack cases, fill to full, overflow, tie handling in sort
   script_row_type opening_script [SCRIPT_LEN] = '{
      '{'{rss_pkg::FUNC_POP,  64'h0, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_EMPTY, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_READ, 64'h0, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_EMPTY, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_SORT, 64'h0, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_EMPTY, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'h0, 16'sh8000}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 16'sh7FFF}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'h0123_4567_89AB_CDEF, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 16'shFFFF}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'h5555_5555_5555_5555, 16'sd100}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'h8000_0000_0000_0001, 16'sd100}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'hFEDC_BA98_7654_3210, 16'sd100}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'h0000_0000_0000_0001, 16'sh8000}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_PUSH, 64'h1234_0000_0000_4321, 16'sd5}, 1'b1,
        '{rss_pkg::STATUS_FULL, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_READ, 64'h0, 16'sh0}, 1'b0, '{2'd0, 64'h0, 16'sh0, 1'b0}},
      '{'{rss_pkg::FUNC_SORT, 64'h0, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_READ, 64'h0, 16'sh0}, 1'b0, '{2'd0, 64'h0, 16'sh0, 1'b0}},
      '{'{rss_pkg::FUNC_POP,  64'h0, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_SORT, 64'h0, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_READ, 64'h0, 16'sh0}, 1'b0, '{2'd0, 64'h0, 16'sh0, 1'b0}},
      '{'{rss_pkg::FUNC_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 16'sh7FFF}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_SORT, 64'h0, 16'sh0}, 1'b1,
        '{rss_pkg::STATUS_OK, 64'h0, 16'sh0, 1'b1}},
      '{'{rss_pkg::FUNC_READ, 64'h0, 16'sh0}, 1'b0, '{2'd0, 64'h0, 16'sh0, 1'b0}}
   };

   record_stack_with_sort i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // single status-only answer (push, pop, sort, empty cases)
   function automatic rss_pkg::rsp_type status_result(input logic [1:0] status);
      return '{status, 64'h0, 16'sh0, 1'b1};
   endfunction

   // apply one operation to the shadow stack and list the results it causes
   function automatic void predict_stack_results(input rss_pkg::req_type r,
                                                 output rss_pkg::rsp_type res [$]);
      rss_pkg::rec_type swap;
      int               pass;
      int               pos;
      int               idx;
      res = {};
      if (r.func == rss_pkg::FUNC_PUSH) begin
         if (shadow_fill >= rss_pkg::DEPTH) begin
            res.push_back(status_result(rss_pkg::STATUS_FULL));
         end else begin
            shadow_stack[shadow_fill] = '{r.record_key, r.score};
            shadow_fill++;
            res.push_back(status_result(rss_pkg::STATUS_OK));
         end
      end else if (shadow_fill == 0) begin
         res.push_back(status_result(rss_pkg::STATUS_EMPTY));
      end else if (r.func == rss_pkg::FUNC_POP) begin
         shadow_fill--;
         res.push_back(status_result(rss_pkg::STATUS_OK));
      end else if (r.func == rss_pkg::FUNC_READ) begin
         for (idx = int'(shadow_fill) - 1; idx >= 0; idx--) begin
            res.push_back('{rss_pkg::STATUS_OK, shadow_stack[idx].key,
                            shadow_stack[idx].score, idx == 0});
         end
      end else begin
         // stable bubble sort, highest score sinks to the bottom
         for (pass = 0; pass + 1 < int'(shadow_fill); pass++) begin
            for (pos = 0; pos + 1 < int'(shadow_fill) - pass; pos++) begin
               if (shadow_stack[pos].score < shadow_stack[pos + 1].score) begin
                  swap                  = shadow_stack[pos];
                  shadow_stack[pos]     = shadow_stack[pos + 1];
                  shadow_stack[pos + 1] = swap;
               end
            end
         end
         res.push_back(status_result(rss_pkg::STATUS_OK));
      end
   endfunction

   // offer one item, hold it until taken, then queue its expected results
   task automatic send_item(input rss_pkg::req_type r, input bit typed,
                            input rss_pkg::rsp_type want);
      rss_pkg::rsp_type produced [$];
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_stack_results(r, produced);
      if (typed) begin
         pending_results.push_back(want);
      end else begin
         foreach (produced[i]) pending_results.push_back(produced[i]);
      end
   endtask

   // random result-side stalls in bursts
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rss_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result %0d: unexpected, got status %0d key %h score %0d last %0b",
                        result_index, rsp_data.status, rsp_data.out_key,
                        rsp_data.out_score, rsp_data.last_of_run);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.out_key !== want.out_key ||
                rsp_data.out_score !== want.out_score ||
                rsp_data.last_of_run !== want.last_of_run) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result %0d: expected status %0d key %h score %0d last %0b",
                           result_index, want.status, want.out_key, want.out_score,
                           want.last_of_run);
                  $display("result %0d:      got status %0d key %h score %0d last %0b",
                           result_index, rsp_data.status, rsp_data.out_key,
                           rsp_data.out_score, rsp_data.last_of_run);
               end
            end
         end
         result_index++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("record_stack_with_sort: mismatch");
         $finish;
      end
   end

   initial begin
      rss_pkg::req_type item;
      rss_pkg::rsp_type none;
      int unsigned      push_pct;
      int unsigned      pick;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      none           = '0;
      shadow_fill    = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      result_index   = 0;
      gap_odds       = 0;
      stall_odds     = 0;
      push_pct       = 50;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // walk the opening script with light idling
      gap_odds   = 4;
      stall_odds = 5;
      foreach (opening_script[i])
         send_item(opening_script[i].req, opening_script[i].typed, opening_script[i].want);

      // random operations in segments of varying mix and idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else if (n % SEGMENT_LEN == 0) begin
            push_pct = $urandom_range(20, 75);
            case ($urandom_range(0, 3))
               0: begin gap_odds = 0; stall_odds = 0; end
               1: begin gap_odds = 2; stall_odds = 3; end
               default: begin gap_odds = 6; stall_odds = 8; end
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < push_pct) begin
            item.func = rss_pkg::FUNC_PUSH;
         end else begin
            case ($urandom_range(0, 2))
               0: item.func = rss_pkg::FUNC_POP;
               1: item.func = rss_pkg::FUNC_READ;
               default: item.func = rss_pkg::FUNC_SORT;
            endcase
         end
         case ($urandom_range(0, 9))
            0: item.record_key = 64'h0;
            1: item.record_key = 64'hFFFF_FFFF_FFFF_FFFF;
            default: item.record_key = {$urandom(), $urandom()};
         endcase
         // small score range makes ties, which exercise sort stability
         case ($urandom_range(0, 7))
            0: item.score = 16'sh8000;
            1: item.score = 16'sh7FFF;
            2, 3: item.score = 16'(int'($urandom_range(0, 4)) - 2);
            default: item.score = 16'($urandom());
         endcase
         send_item(item, 1'b0, none);
      end
      req_valid <= 1'b0;

      // drain outstanding results, then allow for stray output
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("record_stack_with_sort: match");
      end else begin
         $display("record_stack_with_sort: mismatch");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+src
src/rss_pkg.sv
src/rss_store.sv
src/rss_cmp_swap.sv
src/record_stack_with_sort.sv
dv/record_stack_with_sort_test.sv
